// ----- rtl/core/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants for the maximum-frequency stack.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int FIELD_VALUE_BITS = 8;
  localparam int FIELD_TOP_BITS   = 7;

  // Operation codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH_RD,
    CMD_PUSH_LINK,
    CMD_PUSH_WR,
    CMD_POP_RD,
    CMD_POP_ENTRY,
    CMD_POP_WR,
    CMD_ERROR
  } mfs_cmd_t;

  // Status returned to the controller.
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic clear_done;
  } mfs_status_t;

endpackage

// ----- rtl/core/mfs_if.sv -----
// ----------------------------------------------------------------------------
// mfs_in_if / mfs_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface mfs_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] push_value;
  modport source (output valid, func, push_value, input ready);
  modport sink (input valid, func, push_value, output ready);
endinterface

interface mfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] popped_value;
  logic [1:0] status;
  logic [6:0] top_frequency;
  modport source (output valid, popped_value, status, top_frequency, input ready);
  modport sink (input valid, popped_value, status, top_frequency, output ready);
endinterface

// ----- rtl/core/mfs_datapath.sv -----
// ----------------------------------------------------------------------------
// mfs_datapath
// Count, level-head, entry and free-slot memories with their pointers.
// ----------------------------------------------------------------------------
module mfs_datapath
  import mfs_pkg::*;
#(
  parameter int VALUE_BITS = 8,
  parameter int CAPACITY   = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mfs_cmd_t                  cmd,
  input  logic                      in_func,
  input  logic [FIELD_VALUE_BITS-1:0] in_value,
  output mfs_status_t               stat,
  output logic [FIELD_VALUE_BITS-1:0] res_value,
  output logic [FIELD_TOP_BITS-1:0] res_top
);

  localparam int VALUES = 1 << VALUE_BITS;
  localparam int SB     = $clog2(CAPACITY);
  localparam int LB     = $clog2(CAPACITY + 1);
  localparam int VB     = VALUE_BITS;
  localparam int CLR    = (VALUES > CAPACITY) ? VALUES : CAPACITY;
  localparam int CB     = $clog2(CLR) + 1;

  // Memories; the count and head arrays are swept clear after reset.
  logic [LB-1:0] count_mem [VALUES];
  logic [SB:0]   head_mem  [CAPACITY];
  logic [VB-1:0] value_mem [CAPACITY];
  logic [SB:0]   link_mem  [CAPACITY];
  logic [SB-1:0] free_mem  [CAPACITY];

  logic [LB-1:0] free_top;
  logic [LB-1:0] used_high;
  logic [LB-1:0] highest;
  logic [CB-1:0] clr_idx;
  logic          clearing;

  logic [VB-1:0] v;
  logic          op;
  logic [LB-1:0] cnt_rd;
  logic [SB:0]   head_rd;
  logic [SB-1:0] free_rd;
  logic [VB-1:0] val_rd;
  logic [SB:0]   link_rd;
  logic [SB-1:0] slot;
  logic [LB-1:0] level;
  logic [SB-1:0] hidx;

  localparam logic [SB:0] NONE = (SB + 1)'(CAPACITY);

  assign hidx = SB'(highest - LB'(1));
  assign level = cnt_rd + LB'(1);

  // Status toward the controller.
  always_comb begin
    stat.is_pop     = op;
    stat.full       = (used_high - free_top) >= LB'(CAPACITY);
    stat.empty      = (highest == '0);
    stat.clear_done = !clearing;
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
      used_high <= '0;
      highest <= '0;
      clr_idx <= '0;
      clearing <= 1'b1;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + CB'(1);
        if (clr_idx == CB'(CLR - 1)) clearing <= 1'b0;
      end
      case (cmd)
        CMD_PUSH_WR: begin
          if (free_top != '0) free_top <= free_top - LB'(1);
          else used_high <= used_high + LB'(1);
          if (level > highest) highest <= level;
        end
        CMD_POP_WR: begin
          free_top <= free_top + LB'(1);
          if (link_rd == NONE) highest <= highest - LB'(1);
        end
        default: ;
      endcase
    end
  end

  // Memory side: latch the item, registered reads, then writes.
  // The popped copy sits at the highest level, so its value's count equals
  // that level and needs no read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_idx < CB'(VALUES)) count_mem[clr_idx[VB-1:0]] <= '0;
      if (clr_idx < CB'(CAPACITY)) head_mem[clr_idx[SB-1:0]] <= NONE;
    end
    case (cmd)
      CMD_LOAD: begin
        op <= in_func;
        v  <= in_value[VB-1:0];
        res_value <= '0;
      end
      CMD_PUSH_RD: begin
        cnt_rd  <= count_mem[v];
        free_rd <= free_mem[SB'(free_top - LB'(1))];
      end
      CMD_PUSH_LINK: begin
        head_rd <= head_mem[SB'(level - LB'(1))];
        slot    <= (free_top != '0) ? free_rd : SB'(used_high);
      end
      CMD_PUSH_WR: begin
        value_mem[slot] <= v;
        link_mem[slot]  <= head_rd;
        head_mem[SB'(level - LB'(1))] <= {1'b0, slot};
        count_mem[v] <= level;
      end
      CMD_POP_RD: begin
        head_rd <= head_mem[hidx];
      end
      CMD_POP_ENTRY: begin
        val_rd  <= value_mem[SB'(head_rd)];
        link_rd <= link_mem[SB'(head_rd)];
      end
      CMD_POP_WR: begin
        head_mem[hidx] <= link_rd;
        free_mem[SB'(free_top)] <= SB'(head_rd);
        count_mem[val_rd] <= highest - LB'(1);
        res_value <= FIELD_VALUE_BITS'(val_rd);
      end
      default: ;
    endcase
  end

  assign res_top = FIELD_TOP_BITS'(highest);

endmodule

// ----- rtl/core/mfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer: clear sweep, then load, decide, read, write and result per item (refused items skip read and write).
// ----------------------------------------------------------------------------
module mfs_ctrl
  import mfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mfs_status_t stat,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output mfs_cmd_t    cmd
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DECIDE, S_RD, S_WR, S_OUT} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  // Command decode per state.
  always_comb begin
    cmd = CMD_NONE;
    case (state)
      S_IDLE:   if (in_valid) cmd = CMD_LOAD;
      S_DECIDE: begin
        if (stat.is_pop) cmd = stat.empty ? CMD_ERROR : CMD_POP_RD;
        else cmd = stat.full ? CMD_ERROR : CMD_PUSH_RD;
      end
      S_RD:     cmd = stat.is_pop ? CMD_POP_ENTRY : CMD_PUSH_LINK;
      S_WR:     cmd = stat.is_pop ? CMD_POP_WR : CMD_PUSH_WR;
      default:  cmd = CMD_NONE;
    endcase
  end

  // State and registered result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
      out_status <= STATUS_OK;
    end else begin
      case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_DECIDE;
        S_DECIDE: begin
          if (cmd == CMD_ERROR) begin
            out_status <= stat.is_pop ? STATUS_POP_EMPTY : STATUS_PUSH_FULL;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            out_status <= STATUS_OK;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/max_frequency_stack.sv -----
// ----------------------------------------------------------------------------
// max_frequency_stack
// Stack that pops the most frequent value, newest first among ties.
// Flow: a push or pop result is presented after the decide, read and write
// states; a refused push or pop presents its result straight from decide.
// A new item is taken only after the result hand-off; an item steps through load,
// decide with its read, dependent read, write and hand-off (refused: decide, hand-off).
// Reset: synchronous; afterwards a sweep over 2^VALUE_BITS entries (CAPACITY if
// larger) clears the count table and level heads; no item is accepted then.
// ----------------------------------------------------------------------------
module max_frequency_stack
  import mfs_pkg::*;
#(
  parameter int VALUE_BITS = 8,
  parameter int CAPACITY   = 64
) (
  input logic clk,
  input logic rst,
  mfs_in_if.sink    req,
  mfs_out_if.source res
);

  mfs_cmd_t    cmd;
  mfs_status_t stat;
  logic [FIELD_VALUE_BITS-1:0] res_value;
  logic [FIELD_TOP_BITS-1:0]   res_top;
  logic [1:0] st;

  mfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready), .out_status(st), .cmd(cmd)
  );

  mfs_datapath #(.VALUE_BITS(VALUE_BITS), .CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_func(req.func), .in_value(req.push_value),
    .stat(stat), .res_value(res_value), .res_top(res_top)
  );

  assign res.status = st;
  assign res.popped_value = res_value;
  assign res.top_frequency = res_top;

  // Errors carry zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != STATUS_OK |-> res.popped_value == '0)
    else $error("error result with nonzero data");

  // No item is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready)
    else $error("input ready during pending result");

  // Top level never exceeds capacity.
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.top_frequency <= FIELD_TOP_BITS'(CAPACITY))
    else $error("top frequency out of range");

endmodule

// ----- tb/tb_max_frequency_stack.sv -----
// ----------------------------------------------------------------------------
// tb_max_frequency_stack
// Drives push and pop items with random gaps and backpressure, predicts each
// result from a behavioral frequency stack and checks every result field.
// ----------------------------------------------------------------------------
module tb_max_frequency_stack;
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic       func;
    logic [7:0] push_value;
  } op_item_t;

  typedef struct packed {
    logic [7:0] popped_value;
    logic [1:0] status;
    logic [6:0] top_frequency;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfs_in_if  req ();
  mfs_out_if res ();

  max_frequency_stack #(.VALUE_BITS(8), .CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source)
  );

  always #1 clk = ~clk;

  // Behavioral model of the stack: per-level lists of values, newest last.
  int       freq_of [256];
  logic [7:0] level_list [CAP][$];
  int       held_copies;
  int       peak_level;

  op_item_t pending_ops [$];
  result_t  expected_results [$];
  int       errors = 0;
  int       hold_off = 0;
  bit       stim_done = 0;
  int       cycles = 0;

  function automatic result_t predict_op(op_item_t it);
    result_t r;
    int lvl;
    r = '0;
    if (it.func == FUNC_PUSH) begin
      if (held_copies >= CAP) begin
        r.status = STATUS_PUSH_FULL;
      end else begin
        freq_of[it.push_value]++;
        lvl = freq_of[it.push_value];
        level_list[lvl-1].push_back(it.push_value);
        held_copies++;
        if (lvl > peak_level) peak_level = lvl;
      end
    end else begin
      if (peak_level == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else begin
        r.popped_value = level_list[peak_level-1].pop_back();
        freq_of[r.popped_value]--;
        held_copies--;
        if (level_list[peak_level-1].size() == 0) peak_level--;
      end
    end
    r.top_frequency = peak_level[6:0];
    return r;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Driver: present queued items, hold valid across back-to-back items.
  int  send_gap = 0;
  bit  pause_for_drain = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.func <= 1'b0;
      req.push_value <= '0;
    end else if (req.valid && !req.ready) begin
      // Hold the item until accepted.
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_op(pending_ops.pop_front()));
        send_gap = rand_gap();
      end
      if (pause_for_drain && pending_ops.size() == 200) begin
        if (expected_results.size() == 0) pause_for_drain = 0;
        req.valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        req.valid <= 1'b1;
        req.func <= pending_ops[0].func;
        req.push_value <= pending_ops[0].push_value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure and field-by-field comparison.
  int sink_gap = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.popped_value, res.status, res.top_frequency};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %0d actual %0d", $time,
                     want.popped_value, got.popped_value);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
            errors++;
          end
          if (got.top_frequency !== want.top_frequency) begin
            $display("%0t: top_frequency expected %0d actual %0d", $time,
                     want.top_frequency, got.top_frequency);
            errors++;
          end
        end
        sink_gap = rand_gap();
      end
      if (sink_gap > 0) begin
        sink_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_op(logic f, logic [7:0] v);
    op_item_t it;
    it.func = f;
    it.push_value = v;
    pending_ops.push_back(it);
  endtask

  initial begin
    int mode, depth, sel;
    logic [7:0] pool [4];
    for (int i = 0; i < 256; i++) freq_of[i] = 0;
    held_copies = 0;
    peak_level = 0;

    // Directed: pop on empty, extremes, ties, one value filling the store.
    add_op(FUNC_POP, 8'hFF);
    add_op(FUNC_PUSH, 8'h00);
    add_op(FUNC_PUSH, 8'hFF);
    add_op(FUNC_PUSH, 8'hFF);
    add_op(FUNC_PUSH, 8'h00);
    add_op(FUNC_POP, 8'h00);
    add_op(FUNC_POP, 8'h00);
    add_op(FUNC_POP, 8'h00);
    add_op(FUNC_POP, 8'h00);
    add_op(FUNC_POP, 8'h00);
    for (int i = 0; i < CAP; i++) add_op(FUNC_PUSH, 8'hA5);
    add_op(FUNC_PUSH, 8'h5A);
    add_op(FUNC_PUSH, 8'hA5);
    for (int i = 0; i < CAP + 1; i++) add_op(FUNC_POP, 8'h00);

    // Random: phases of push-heavy, pop-heavy and balanced traffic over
    // small value pools so frequencies climb, plus full-range noise.
    while (pending_ops.size() < 1600) begin
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) pool[k] = 8'($urandom);
      depth = $urandom_range(10, 90);
      for (int i = 0; i < depth; i++) begin
        sel = $urandom_range(0, 99);
        if (mode == 0) add_op(sel < 80 ? FUNC_PUSH : FUNC_POP, pool[$urandom_range(0, 3)]);
        else if (mode == 1) add_op(sel < 25 ? FUNC_PUSH : FUNC_POP, pool[$urandom_range(0, 3)]);
        else if (mode == 2) add_op(sel < 50 ? FUNC_PUSH : FUNC_POP, pool[$urandom_range(0, 1)]);
        else add_op(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end

    pause_for_drain = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/mfs_pkg.sv
rtl/core/mfs_if.sv
rtl/core/mfs_datapath.sv
rtl/core/mfs_ctrl.sv
rtl/core/max_frequency_stack.sv
tb/tb_max_frequency_stack.sv
